// File: src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the lru key/value cache
// sizes, request and result words, request mode codes
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } res_t;

endpackage

// File: src/lkv_in_reg.sv
// ----------------------------------------------------------------------------
// lkv_in_reg: request input register
// holds one accepted request until the store consumes it
// ----------------------------------------------------------------------------
module lkv_in_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  lkv_pkg::req_t req_in,
    input  logic          advance,
    output logic          req_valid,
    output lkv_pkg::req_t req_out
);

    logic          valid_reg;
    logic          valid_next;
    lkv_pkg::req_t req_reg;
    logic          load;

    // stall only while holding a request that cannot move on
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_in;
        end
    end

    assign req_valid = valid_reg;
    assign req_out   = req_reg;

endmodule

// File: src/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store: entry store with parallel lookup and recency ranking
// decides hit, fill or eviction and updates the entries on commit
// ----------------------------------------------------------------------------
module lkv_store
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lkv_pkg::CAP_W-1:0]   capacity,
    input  logic                        commit,
    input  lkv_pkg::req_t               req,
    output lkv_pkg::res_t               res
);

    logic [lkv_pkg::KEY_W-1:0] key_mem   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] value_mem [lkv_pkg::ENTRIES];
    logic [lkv_pkg::IDX_W-1:0] rank_reg  [lkv_pkg::ENTRIES];
    logic [lkv_pkg::IDX_W-1:0] rank_next [lkv_pkg::ENTRIES];
    logic [lkv_pkg::ENTRIES-1:0] valid_reg;
    logic [lkv_pkg::ENTRIES-1:0] valid_next;
    logic [lkv_pkg::CNT_W-1:0] occ_reg;
    logic [lkv_pkg::CNT_W-1:0] occ_next;

    logic [lkv_pkg::CNT_W-1:0] cap_eff;
    logic [lkv_pkg::CNT_W-1:0] occ_last;
    logic [lkv_pkg::ENTRIES-1:0] hit_vec;
    logic [lkv_pkg::ENTRIES-1:0] victim_vec;
    logic [lkv_pkg::IDX_W-1:0] hit_idx;
    logic [lkv_pkg::IDX_W-1:0] victim_idx;
    logic [lkv_pkg::IDX_W-1:0] free_idx;
    logic [lkv_pkg::IDX_W-1:0] sel_idx;
    logic [lkv_pkg::IDX_W-1:0] old_rank;
    logic active;
    logic full;
    logic do_hit;
    logic do_evict;
    logic do_fill;
    logic touch;
    logic is_put;

    // capacity saturates at the number of entries
    always_comb
    begin
        if (32'(capacity) > lkv_pkg::ENTRIES)
        begin
            cap_eff = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
        end
        else
        begin
            cap_eff = lkv_pkg::CNT_W'(capacity);
        end
    end

    assign occ_last = occ_reg - lkv_pkg::CNT_W'(1);

    // per-entry compares, least recent entry holds rank occupancy-1
    always_comb
    begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            hit_vec[i]    = valid_reg[i] && (key_mem[i] == req.key);
            victim_vec[i] = valid_reg[i] && (lkv_pkg::CNT_W'(rank_reg[i]) == occ_last);
        end
    end

    // lowest index wins
    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = lkv_pkg::IDX_W'(i);
            end
            if (victim_vec[i])
            begin
                victim_idx = lkv_pkg::IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = lkv_pkg::IDX_W'(i);
            end
        end
    end

    assign is_put   = (req.mode == lkv_pkg::MODE_PUT);
    assign active   = (cap_eff != '0);
    assign full     = (occ_reg >= cap_eff);
    assign do_hit   = active && (|hit_vec);
    assign do_evict = active && !(|hit_vec) && is_put && full;
    assign do_fill  = active && !(|hit_vec) && is_put && !full;
    assign touch    = do_hit || do_evict || do_fill;

    always_comb
    begin
        if (do_hit)
        begin
            sel_idx = hit_idx;
        end
        else if (do_evict)
        begin
            sel_idx = victim_idx;
        end
        else
        begin
            sel_idx = free_idx;
        end
    end

    assign old_rank = rank_reg[sel_idx];

    always_comb
    begin
        res.found       = do_hit;
        res.read_value  = (do_hit && !is_put) ? value_mem[hit_idx] : '0;
        res.evicted     = do_evict;
        res.evicted_key = do_evict ? key_mem[victim_idx] : '0;
    end

    // promote the touched entry, age the ones that were more recent, or every valid one on a fill
    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (touch)
            begin
                if (lkv_pkg::IDX_W'(i) == sel_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (do_fill || (rank_reg[i] < old_rank)))
                begin
                    rank_next[i] = rank_reg[i] + lkv_pkg::IDX_W'(1);
                end
            end
        end
        if (do_fill)
        begin
            valid_next[sel_idx] = 1'b1;
            occ_next            = occ_reg + lkv_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            if (do_evict || do_fill)
            begin
                key_mem[sel_idx] <= req.key;
            end
            if (touch && is_put)
            begin
                value_mem[sel_idx] <= req.value;
            end
        end
    end

endmodule

// File: src/lkv_out_reg.sv
// ----------------------------------------------------------------------------
// lkv_out_reg: result output register
// holds one result word until the consumer takes it
// ----------------------------------------------------------------------------
module lkv_out_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  lkv_pkg::res_t res_in,
    output logic          can_take,
    output logic          out_valid,
    input  logic          out_stall,
    output lkv_pkg::res_t res_out
);

    logic          valid_reg;
    logic          valid_next;
    lkv_pkg::res_t res_reg;

    // room when empty or when the held word leaves this edge
    assign can_take = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// File: src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache, lru replacement
// get/put requests in, one result word out per request
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  config   | cfg_valid / cfg_ready    | capacity[4:0]
//  request  | in_valid / in_stall      | mode, key[31:0], value[31:0]
//  result   | out_valid / out_stall    | found, read_value, evicted, evicted_key
//
//  one request per cycle sustained while out_stall is low; a request word
//  passes through the input register, then lookup and update of all
//  entries in one pass into the result register
//  reset clears valid bits, recency ranks and occupancy; capacity returns to 16
//  out_stall holds the result register and backs up into in_stall in the
//  same cycle once the input register is also full
//
module lru_key_value_cache
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]   capacity,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic signed [lkv_pkg::KEY_W-1:0] key,
    input  logic signed [lkv_pkg::VAL_W-1:0] value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic signed [lkv_pkg::VAL_W-1:0] read_value,
    output logic                        evicted,
    output logic signed [lkv_pkg::KEY_W-1:0] evicted_key
);

    logic [lkv_pkg::CAP_W-1:0] capacity_reg;
    lkv_pkg::req_t req_in;
    lkv_pkg::req_t req_q;
    lkv_pkg::res_t res_d;
    lkv_pkg::res_t res_q;
    logic          req_q_valid;
    logic          can_take;
    logic          advance;

    // config always taken; user must let writes land only while idle, unchecked
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkv_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= capacity;
        end
    end

    assign req_in.mode  = mode;
    assign req_in.key   = key;
    assign req_in.value = value;

    // request moves from input register into the store when result has room
    assign advance = req_q_valid && can_take;

    lkv_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_in    (req_in),
        .advance   (advance),
        .req_valid (req_q_valid),
        .req_out   (req_q)
    );

    // lookup and state update commit on the same edge the result is loaded
    lkv_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .commit   (advance),
        .req      (req_q),
        .res      (res_d)
    );

    lkv_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_d),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_q)
    );

    assign found       = res_q.found;
    assign read_value  = res_q.read_value;
    assign evicted     = res_q.evicted;
    assign evicted_key = res_q.evicted_key;

    // a hit never evicts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && evicted))
        else $error("hit and eviction reported together");

    // an eviction only comes from a put, which returns no data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> (read_value == '0))
        else $error("eviction result carries read data");

    // a request handed to the store shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("committed request produced no result");

    // input stalls only while a request is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> req_q_valid)
        else $error("input stalled with empty input register");

endmodule

// File: tb/lru_key_value_cache_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test: self-checking testbench for the lru key/value cache
// a directed part walks the put/get corner cases and capacity changes, then
// random get/put traffic over small key pools runs under several capacities;
// every result word is compared field by field against an in-bench lru model
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;

    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 70;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [lkv_pkg::CAP_W-1:0]          capacity;
    logic                               in_valid;
    logic                               in_stall;
    logic                               mode;
    logic signed [lkv_pkg::KEY_W-1:0]   key;
    logic signed [lkv_pkg::VAL_W-1:0]   value;
    logic                               out_valid;
    logic                               out_stall;
    logic                               found;
    logic signed [lkv_pkg::VAL_W-1:0]   read_value;
    logic                               evicted;
    logic signed [lkv_pkg::KEY_W-1:0]   evicted_key;

    // lru model state
    logic [lkv_pkg::KEY_W-1:0]          slot_key [lkv_pkg::ENTRIES];
    logic [lkv_pkg::VAL_W-1:0]          slot_data [lkv_pkg::ENTRIES];
    bit                                 slot_live [lkv_pkg::ENTRIES];
    int                                 slot_age [lkv_pkg::ENTRIES];
    int                                 live_count;
    int                                 cap_setting;

    lkv_pkg::res_t                      pending_results [$];
    logic [lkv_pkg::KEY_W-1:0]          key_pool [32];
    int                                 pool_size;
    int                                 error_count;
    int                                 cycle_count;

    // idling controls shared with the stall process
    bit                                 idle_en;
    bit                                 stall_en;
    bit                                 hold_off;

    lru_key_value_cache dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .capacity    (capacity),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // make slot s most recent; live slots younger than old_age get one older
    function automatic void touch_slot(input int s, input int old_age);
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (slot_live[i] && i != s && slot_age[i] < old_age)
                slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    // expected result of one request, updating the model on the way
    function automatic lkv_pkg::res_t lru_access(input logic req_mode,
                                                 input logic [lkv_pkg::KEY_W-1:0] req_key,
                                                 input logic [lkv_pkg::VAL_W-1:0] req_value);
        lkv_pkg::res_t r;
        int   hit;
        int   victim;
        int   eff;
        r      = '0;
        hit    = -1;
        victim = -1;
        eff    = (cap_setting > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : cap_setting;
        // capacity zero: store acts empty, result all zero
        if (eff == 0)
            return r;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (hit < 0 && slot_live[i] && slot_key[i] == req_key)
                hit = i;
        end
        if (hit >= 0)
        begin
            r.found = 1'b1;
            if (req_mode == lkv_pkg::MODE_GET)
                r.read_value = slot_data[hit];
            else
                slot_data[hit] = req_value;
            touch_slot(hit, slot_age[hit]);
            return r;
        end
        if (req_mode == lkv_pkg::MODE_GET)
            return r;
        // full (or capacity lowered under occupancy): replace the oldest
        if (live_count >= eff)
        begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            begin
                if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                    victim = i;
            end
            if (victim >= 0)
            begin
                r.evicted       = 1'b1;
                r.evicted_key   = slot_key[victim];
                slot_key[victim]  = req_key;
                slot_data[victim] = req_value;
                touch_slot(victim, slot_age[victim]);
                return r;
            end
        end
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            if (!slot_live[i])
            begin
                touch_slot(i, lkv_pkg::ENTRIES + 1);
                slot_live[i] = 1'b1;
                slot_key[i]  = req_key;
                slot_data[i] = req_value;
                live_count++;
                break;
            end
        end
        return r;
    endfunction

    // offer one request word and hold it until taken
    task automatic send_request(input logic req_mode,
                                input logic [lkv_pkg::KEY_W-1:0] req_key,
                                input logic [lkv_pkg::VAL_W-1:0] req_value);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= req_mode;
        key      <= req_key;
        value    <= req_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(lru_access(req_mode, req_key, req_value));
    endtask

    // mostly keys from the pool so hits and evictions happen, some fresh keys
    task automatic send_random_request();
        logic                      m;
        logic [lkv_pkg::KEY_W-1:0] k;
        m = ($urandom_range(0, 1) == 1) ? lkv_pkg::MODE_PUT : lkv_pkg::MODE_GET;
        if ($urandom_range(0, 9) == 0)
            k = $urandom;
        else
            k = key_pool[$urandom_range(0, pool_size - 1)];
        send_request(m, k, $urandom);
    endtask

    task automatic fill_pool(input int n);
        pool_size = (n > 32) ? 32 : n;
        for (int i = 0; i < 32; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        if (pool_size > 2)
            key_pool[1] = 32'h7FFF_FFFF;
    endtask

    // stop offering and wait for every expected word plus the pipeline depth
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input int c);
        drain();
        cfg_valid <= 1'b1;
        capacity  <= c[lkv_pkg::CAP_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        cap_setting = c;
    endtask

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // extremes of key and value, get miss, get hit, put hit, at reset capacity
    task automatic test_basic_get_put();
        send_request(lkv_pkg::MODE_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(lkv_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lkv_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(lkv_pkg::MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(lkv_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(lkv_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // capacity dropped below occupancy: new keys evict one each, old ones still hit
    task automatic test_shrunk_capacity();
        write_capacity(2);
        send_request(lkv_pkg::MODE_PUT, 32'h1234_5678, 32'hA5A5_A5A5);
        send_request(lkv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(lkv_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_request(lkv_pkg::MODE_GET, 32'h1234_5678, 32'h0000_0000);
        write_capacity(1);
        send_request(lkv_pkg::MODE_PUT, 32'h55AA_55AA, 32'hFFFF_FFFF);
        send_request(lkv_pkg::MODE_GET, 32'h55AA_55AA, 32'h0000_0000);
    endtask

    // capacity zero: puts ignored, gets miss even on keys still held
    task automatic test_zero_capacity();
        write_capacity(0);
        send_request(lkv_pkg::MODE_PUT, 32'h0000_0001, 32'h0000_0001);
        send_request(lkv_pkg::MODE_GET, 32'h55AA_55AA, 32'h0000_0000);
        send_request(lkv_pkg::MODE_GET, 32'h0000_0001, 32'h0000_0000);
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_output_backpressure();
        write_capacity(6);
        fill_pool(9);
        idle_en  = 1'b0;
        hold_off = 1'b1;
        repeat (40) send_random_request();
        idle_en  = 1'b1;
    endtask

    // random traffic under a run of capacities, saturating ones included
    task automatic test_random_traffic();
        int phase_caps [10];
        int c;
        int eff;
        phase_caps = '{16, 1, 31, 5, 2, 0, 8, 17, 0, 16};
        phase_caps[8] = $urandom_range(0, 31);
        for (int p = 0; p < 10; p++)
        begin
            c = phase_caps[p];
            write_capacity(c);
            // every third phase runs with no idling on either side
            idle_en  = (p % 3 != 2);
            stall_en = idle_en;
            eff = (c > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : c;
            fill_pool((eff == 0) ? 8 : eff + $urandom_range(1, 8));
            repeat (PHASE_ITEMS) send_random_request();
        end
        idle_en  = 1'b1;
        stall_en = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (stall_en && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: each taken word against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        lkv_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("found", 32'(want.found), 32'(found));
                check_field("read_value", want.read_value, read_value);
                check_field("evicted", 32'(want.evicted), 32'(evicted));
                check_field("evicted_key", want.evicted_key, evicted_key);
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        capacity  <= lkv_pkg::CAP_RESET;
        in_valid  <= 1'b0;
        mode      <= lkv_pkg::MODE_GET;
        key       <= '0;
        value     <= '0;
        error_count = 0;
        idle_en     = 1'b1;
        stall_en    = 1'b1;
        hold_off    = 1'b0;
        live_count  = 0;
        cap_setting = lkv_pkg::CAP_RESET;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            slot_key[i]  = '0;
            slot_data[i] = '0;
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_get_put();
        test_shrunk_capacity();
        test_zero_capacity();
        test_output_backpressure();
        test_random_traffic();

        // end of stimulus: everything outstanding must come back
        drain();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: lru_key_value_cache.f
src/lkv_pkg.sv
src/lkv_in_reg.sv
src/lkv_store.sv
src/lkv_out_reg.sv
src/lru_key_value_cache.sv
tb/lru_key_value_cache_test.sv
